FILE: hw/rtl/btk_pkg.sv
// btk_pkg: shared types, op codes and the ordering function for the top-k sorted list
// used by btk_ctrl, btk_dp and bounded_top_k_sorted_list_core
package btk_pkg;

	typedef enum logic [1:0] {
		OP_OFFER = 2'd0,
		OP_DUMP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	localparam int ID_W   = 16;
	localparam int REL_W  = 6;
	localparam int RANK_W = 24;
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [REL_W-1:0]  rel;
		logic [RANK_W-1:0] rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_END,
		IDX_ZERO,
		IDX_DEC,
		IDX_INC
	} idx_op_t;

	typedef struct packed {
		logic    capture;
		idx_op_t idx_op;
		logic    rd_en;
		logic    rd_prev;
		logic    wr_en;
		logic    wr_offer;
		logic    set_acc;
		logic    cnt_inc;
		logic    cnt_clear;
		logic    out_load;
		logic    out_entry;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic rel_zero;
		logic cnt_zero;
		logic full;
		logic idx_zero;
		logic idx_last;
		logic better;
		logic out_free;
	} status_t;

	// a strictly ahead of b: higher relevance, then lower rank
	function automatic logic is_better(entry_t a, entry_t b);
		logic r;
		if (a.rel != b.rel) begin
			r = (a.rel > b.rel);
		end else begin
			r = (a.rank < b.rank);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/btk_ram.sv
// btk_ram: generic single-write, single-read ram with registered read data
// no dependencies
module btk_ram #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 50
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/btk_dp.sv
// btk_dp: datapath of the top-k list: entry ram, count, index, offer and result registers
// depends on btk_pkg and btk_ram
module btk_dp
	import btk_pkg::*;
#(
	parameter int LIST_DEPTH = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   entry_id,
	input  logic [REL_W-1:0]  relevance,
	input  logic [RANK_W-1:0] rank,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic              accepted,
	output logic [POS_W-1:0]  position,
	output logic [CNT_W-1:0]  count,
	output logic              entry_valid,
	output logic [ID_W-1:0]   out_id,
	output logic [REL_W-1:0]  out_relevance,
	output logic [RANK_W-1:0] out_rank,
	output logic              last
);

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int LCNT_W = $clog2(LIST_DEPTH + 1);

	op_t               op_q;
	entry_t            offer_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic              acc_q;
	logic [LCNT_W-1:0] cnt_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]  raddr;
	entry_t            wdata;
	entry_t            rdata;
	logic              full;
	logic              idx_last;

	assign full     = (cnt_q == LCNT_W'(LIST_DEPTH));
	assign idx_last = ((LCNT_W'(idx_q) + LCNT_W'(1)) == cnt_q);
	assign raddr    = cmd.rd_prev ? (idx_q - IDX_W'(1)) : idx_q;
	assign wdata    = cmd.wr_offer ? offer_q : rdata;

	btk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LIST_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(idx_q),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		st.op       = op_q;
		st.rel_zero = (offer_q.rel == '0);
		st.cnt_zero = (cnt_q == '0);
		st.full     = full;
		st.idx_zero = (idx_q == '0);
		st.idx_last = idx_last;
		st.better   = is_better(offer_q, rdata);
		st.out_free = !out_valid_q || !out_stall;
	end

	// offer beat and scan registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q          <= op_t'(op);
			offer_q.id    <= entry_id;
			offer_q.rel   <= relevance;
			offer_q.rank  <= rank;
			pos_q         <= '0;
		end else if (cmd.set_acc) begin
			pos_q <= idx_q;
		end
		case (cmd.idx_op)
			IDX_END:  idx_q <= full ? IDX_W'(LIST_DEPTH - 1) : cnt_q[IDX_W-1:0];
			IDX_ZERO: idx_q <= '0;
			IDX_DEC:  idx_q <= idx_q - IDX_W'(1);
			IDX_INC:  idx_q <= idx_q + IDX_W'(1);
			default:  idx_q <= idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc && !full) begin
				cnt_q <= cnt_q + LCNT_W'(1);
			end
			if (cmd.capture) begin
				acc_q <= 1'b0;
			end else if (cmd.set_acc) begin
				acc_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			count <= CNT_W'(cnt_q);
			if (cmd.out_entry) begin
				kind          <= 1'b1;
				accepted      <= 1'b0;
				position      <= POS_W'(idx_q);
				entry_valid   <= 1'b1;
				out_id        <= rdata.id;
				out_relevance <= rdata.rel;
				out_rank      <= rdata.rank;
				last          <= idx_last;
			end else begin
				kind          <= (op_q == OP_DUMP);
				accepted      <= acc_q;
				position      <= POS_W'(pos_q);
				entry_valid   <= 1'b0;
				out_id        <= '0;
				out_relevance <= '0;
				out_rank      <= '0;
				last          <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/btk_ctrl.sv
// btk_ctrl: controller state machine of the top-k list, sequences scan, shift and dump
// depends on btk_pkg
module btk_ctrl
	import btk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CHKRD,
		S_CHKCMP,
		S_STEP,
		S_CMP,
		S_DRD,
		S_DOUT
	} state_t;

	typedef enum logic {
		A_NONE,
		A_PEND
	} ack_t;

	state_t state_q;
	state_t state_d;
	ack_t   ack_q;
	ack_t   ack_d;

	assign in_stall = (state_q != S_IDLE) || (ack_q == A_PEND);

	always_comb begin
		cmd     = '0;
		cmd.idx_op = IDX_HOLD;
		state_d = state_q;
		ack_d   = ack_q;
		case (state_q)
			S_IDLE: begin
				if (ack_q == A_PEND) begin
					if (st.out_free) begin
						cmd.out_load = 1'b1;
						ack_d        = A_NONE;
					end
				end else if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.op)
					OP_OFFER: begin
						if (st.rel_zero) begin
							ack_d   = A_PEND;
							state_d = S_IDLE;
						end else begin
							cmd.idx_op = IDX_END;
							state_d    = st.full ? S_CHKRD : S_STEP;
						end
					end
					OP_DUMP: begin
						if (st.cnt_zero) begin
							ack_d   = A_PEND;
							state_d = S_IDLE;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_DRD;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_clear = 1'b1;
						ack_d         = A_PEND;
						state_d       = S_IDLE;
					end
					default: begin
						ack_d   = A_PEND;
						state_d = S_IDLE;
					end
				endcase
			end
			S_CHKRD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHKCMP;
			end
			S_CHKCMP: begin
				if (st.better) begin
					state_d = S_STEP;
				end else begin
					ack_d   = A_PEND;
					state_d = S_IDLE;
				end
			end
			S_STEP: begin
				if (st.idx_zero) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_offer = 1'b1;
					cmd.set_acc  = 1'b1;
					cmd.cnt_inc  = 1'b1;
					ack_d        = A_PEND;
					state_d      = S_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				cmd.wr_en = 1'b1;
				if (st.better) begin
					cmd.idx_op = IDX_DEC;
					state_d    = S_STEP;
				end else begin
					cmd.wr_offer = 1'b1;
					cmd.set_acc  = 1'b1;
					cmd.cnt_inc  = 1'b1;
					ack_d        = A_PEND;
					state_d      = S_IDLE;
				end
			end
			S_DRD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_DOUT;
			end
			S_DOUT: begin
				if (st.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_entry = 1'b1;
					if (st.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d    = S_DRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ack_q   <= A_NONE;
		end else begin
			state_q <= state_d;
			ack_q   <= ack_d;
		end
	end

endmodule

FILE: hw/rtl/bounded_top_k_sorted_list_core.sv
// bounded_top_k_sorted_list_core: top level of the bounded top-k sorted list
// depends on btk_pkg, btk_ctrl and btk_dp
//
//  channel | handshake           | fields
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid / in_stall | op, entry_id, relevance, rank
//  out     | out_valid/out_stall | kind, accepted, position, count, entry_valid,
//          |                     | out_id, out_relevance, out_rank, last
//
// one input beat at a time; entries live in a single-port-read ram, one access per cycle
// offer: decode, then a read and compare per entry shifted down, then write the offer
// a full list first reads and compares the last entry; an offer not better is dropped
// dump: read then emit per entry; clear, no-op, ignored offer, empty dump: one result
// out_stall holds the result register and the dump waits on it; in_stall is high while busy
// arst_n empties the list; ram contents need no clearing
module bounded_top_k_sorted_list_core
	import btk_pkg::*;
#(
	parameter int LIST_DEPTH = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   entry_id,
	input  logic [REL_W-1:0]  relevance,
	input  logic [RANK_W-1:0] rank,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic              accepted,
	output logic [POS_W-1:0]  position,
	output logic [CNT_W-1:0]  count,
	output logic              entry_valid,
	output logic [ID_W-1:0]   out_id,
	output logic [REL_W-1:0]  out_relevance,
	output logic [RANK_W-1:0] out_rank,
	output logic              last
);

	cmd_t    cmd;
	status_t st;

	btk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	btk_dp #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.op           (op),
		.entry_id     (entry_id),
		.relevance    (relevance),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.accepted     (accepted),
		.position     (position),
		.count        (count),
		.entry_valid  (entry_valid),
		.out_id       (out_id),
		.out_relevance(out_relevance),
		.out_rank     (out_rank),
		.last         (last)
	);

endmodule
